// ----- sv/lrcs_pkg.sv -----
// lrcs_pkg: shared types and constants for the LBA range crypt segmenter.
// Used by the interfaces, the register block, the segment unit, the top level and the checker.
package lrcs_pkg;

	localparam int LBA_W     = 48;
	localparam int CNT_W     = 16;
	localparam int RUN_W     = LBA_W + 1;
	localparam int DIFF_W    = LBA_W + 2;
	localparam int KEY_W     = 2;
	localparam int APB_DW    = 64;
	localparam int APB_AW    = 6;
	localparam int REG_IDX_W = 3;
	localparam int MAX_KEYS_DEF = 3;

	localparam logic [CNT_W-1:0] SEG_CAP = 16'hFFFF;

	localparam logic [REG_IDX_W-1:0] REG_KEY_COUNT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RANGE_BASE = 3'd1;

	typedef enum logic [1:0] {
		ACT_COPY    = 2'd0,
		ACT_DECRYPT = 2'd1,
		ACT_ENCRYPT = 2'd2
	} act_t;

	typedef struct packed {
		logic [LBA_W-1:0] start_lba;
		logic [CNT_W-1:0] sector_count;
		logic             is_read;
	} in_word_t;

	typedef struct packed {
		act_t             action;
		logic [KEY_W-1:0] key_index;
		logic [LBA_W-1:0] seg_lba;
		logic [CNT_W-1:0] seg_sectors;
		logic [CNT_W-1:0] seg_offset;
		logic             last_segment;
	} out_word_t;

	typedef struct packed {
		logic [LBA_W-1:0] low;
		logic [LBA_W-1:0] high;
	} range_t;

	typedef struct packed {
		logic [LBA_W-1:0] bound;
		logic [RUN_W-1:0] lba;
		logic [CNT_W-1:0] left;
		logic             crypt;
		logic             tail;
	} seg_req_t;

	typedef struct packed {
		logic             emit;
		logic [CNT_W-1:0] n;
	} seg_rsp_t;

endpackage

// ----- sv/lrcs_if.sv -----
// lrcs_if: valid/ready stream interfaces for access words and segment words.
// Depends on lrcs_pkg.
interface lrcs_in_if;
	logic               valid;
	logic               ready;
	lrcs_pkg::in_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lrcs_out_if;
	logic                valid;
	logic                ready;
	lrcs_pkg::out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/lrcs_cfg.sv -----
// lrcs_cfg: APB register file holding key count and key LBA ranges.
// Depends on lrcs_pkg.
module lrcs_cfg #(
	parameter int MAX_KEYS = lrcs_pkg::MAX_KEYS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [lrcs_pkg::APB_AW-1:0]              paddr,
	input  logic [lrcs_pkg::APB_DW-1:0]              pwdata,
	output logic [lrcs_pkg::APB_DW-1:0]              prdata,
	output logic                                     pready,
	output logic [lrcs_pkg::KEY_W-1:0]               key_count,
	output lrcs_pkg::range_t [MAX_KEYS-1:0]          ranges
);

	logic                               wr;
	logic [lrcs_pkg::REG_IDX_W-1:0]     idx;
	logic [lrcs_pkg::KEY_W-1:0]         key_count_q;
	lrcs_pkg::range_t [MAX_KEYS-1:0]    ranges_q;

	assign pready    = 1'b1;
	assign wr        = psel & penable & pwrite;
	assign idx       = paddr[lrcs_pkg::APB_AW-1:lrcs_pkg::APB_AW-lrcs_pkg::REG_IDX_W];
	assign key_count = key_count_q;
	assign ranges    = ranges_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			ranges_q    <= '0;
		end else if (wr) begin
			if (idx == lrcs_pkg::REG_KEY_COUNT) begin
				key_count_q <= pwdata[lrcs_pkg::KEY_W-1:0];
			end
			for (int k = 0; k < MAX_KEYS; k++) begin
				if (idx == lrcs_pkg::REG_IDX_W'(lrcs_pkg::REG_RANGE_BASE + 2*k)) begin
					ranges_q[k].low <= pwdata[lrcs_pkg::LBA_W-1:0];
				end
				if (idx == lrcs_pkg::REG_IDX_W'(lrcs_pkg::REG_RANGE_BASE + 2*k + 1)) begin
					ranges_q[k].high <= pwdata[lrcs_pkg::LBA_W-1:0];
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (idx == lrcs_pkg::REG_KEY_COUNT) begin
			prdata = lrcs_pkg::APB_DW'(key_count_q);
		end
		for (int k = 0; k < MAX_KEYS; k++) begin
			if (idx == lrcs_pkg::REG_IDX_W'(lrcs_pkg::REG_RANGE_BASE + 2*k)) begin
				prdata = lrcs_pkg::APB_DW'(ranges_q[k].low);
			end
			if (idx == lrcs_pkg::REG_IDX_W'(lrcs_pkg::REG_RANGE_BASE + 2*k + 1)) begin
				prdata = lrcs_pkg::APB_DW'(ranges_q[k].high);
			end
		end
	end

endmodule

// ----- sv/lrcs_seg_unit.sv -----
// lrcs_seg_unit: shared subtract/compare unit sizing one segment against a bound.
// Depends on lrcs_pkg.
module lrcs_seg_unit (
	input  lrcs_pkg::seg_req_t req,
	output lrcs_pkg::seg_rsp_t rsp
);

	logic [lrcs_pkg::DIFF_W-1:0] diff;
	logic [lrcs_pkg::DIFF_W-1:0] cnt;
	logic [lrcs_pkg::CNT_W-1:0]  sat;
	logic [lrcs_pkg::CNT_W-1:0]  fit;
	logic                        neg;

	// crypt: bound is inclusive high, so count = high - lba + 1
	assign diff = {2'b00, req.bound} - {1'b0, req.lba};
	assign neg  = diff[lrcs_pkg::DIFF_W-1];
	assign cnt  = diff + lrcs_pkg::DIFF_W'(req.crypt);
	assign sat  = (cnt > lrcs_pkg::DIFF_W'(lrcs_pkg::SEG_CAP)) ? lrcs_pkg::SEG_CAP
		: cnt[lrcs_pkg::CNT_W-1:0];
	assign fit  = (sat < req.left) ? sat : req.left;

	assign rsp.emit = (req.left != '0) && (req.tail || (!neg && cnt != '0));
	assign rsp.n    = req.tail ? req.left : fit;

endmodule

// ----- sv/lba_range_crypt_segmenter.sv -----
// Top level: splits one sector access into copy and crypt segments over the key ranges.
// Each access is worked in steps: accept, a step per range half, an end-of-walk step and a tail
// step on one shared subtract/compare unit; stalls while a segment word waits. A new access is
// accepted only when the walk of the last one is through and the sequencer is idle again.
// Reset: arst_n asynchronous active low; clears sequencer, output valid and working registers (not segment data).
// Depends on lrcs_pkg, lrcs_if, lrcs_cfg, lrcs_seg_unit.
module lba_range_crypt_segmenter #(
	parameter int MAX_KEYS = lrcs_pkg::MAX_KEYS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lrcs_in_if.sink                     req,
	lrcs_out_if.source                  seg,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lrcs_pkg::APB_AW-1:0] paddr,
	input  logic [lrcs_pkg::APB_DW-1:0] pwdata,
	output logic [lrcs_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_COPY  = 4'b0010,
		S_CRYPT = 4'b0100,
		S_TAIL  = 4'b1000
	} state_t;

	localparam logic [lrcs_pkg::KEY_W-1:0] MAX_K = lrcs_pkg::KEY_W'(MAX_KEYS);

	logic [lrcs_pkg::KEY_W-1:0]      key_count;
	lrcs_pkg::range_t [MAX_KEYS-1:0] ranges;

	state_t                          state_q;
	logic [lrcs_pkg::KEY_W-1:0]      idx_q;
	logic [lrcs_pkg::KEY_W-1:0]      nkeys_q;
	logic [lrcs_pkg::RUN_W-1:0]      lba_q;
	logic [lrcs_pkg::CNT_W-1:0]      left_q;
	logic [lrcs_pkg::CNT_W-1:0]      off_q;
	lrcs_pkg::act_t                  crypt_act_q;
	logic                            seg_valid_q;
	lrcs_pkg::out_word_t             seg_data_q;

	logic [lrcs_pkg::LBA_W-1:0]      sel_low;
	logic [lrcs_pkg::LBA_W-1:0]      sel_high;
	lrcs_pkg::seg_req_t              ureq;
	lrcs_pkg::seg_rsp_t              ursp;
	logic                            walk_more;
	logic                            can_emit;
	logic                            step;
	logic                            fire;
	logic [lrcs_pkg::CNT_W-1:0]      left_nxt;

	lrcs_cfg #(.MAX_KEYS(MAX_KEYS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.key_count (key_count),
		.ranges    (ranges)
	);

	always_comb begin
		sel_low  = '0;
		sel_high = '0;
		for (int k = 0; k < MAX_KEYS; k++) begin
			if (idx_q == lrcs_pkg::KEY_W'(k)) begin
				sel_low  = ranges[k].low;
				sel_high = ranges[k].high;
			end
		end
	end

	assign ureq.bound = (state_q == S_CRYPT) ? sel_high : sel_low;
	assign ureq.lba   = lba_q;
	assign ureq.left  = left_q;
	assign ureq.crypt = (state_q == S_CRYPT);
	assign ureq.tail  = (state_q == S_TAIL);

	lrcs_seg_unit u_unit (
		.req (ureq),
		.rsp (ursp)
	);

	assign walk_more = (left_q != '0) && (idx_q < nkeys_q);
	assign can_emit  = !seg_valid_q || seg.ready;
	assign step      = !ursp.emit || can_emit;
	assign fire      = ursp.emit && can_emit &&
		((state_q == S_COPY && walk_more) || state_q == S_CRYPT || state_q == S_TAIL);
	assign left_nxt  = left_q - ursp.n;

	assign req.ready = (state_q == S_IDLE);
	assign seg.valid = seg_valid_q;
	assign seg.data  = seg_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			nkeys_q     <= '0;
			lba_q       <= '0;
			left_q      <= '0;
			off_q       <= '0;
			crypt_act_q <= lrcs_pkg::ACT_ENCRYPT;
			seg_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				seg_valid_q <= 1'b1;
				lba_q       <= lba_q + lrcs_pkg::RUN_W'(ursp.n);
				left_q      <= left_nxt;
				off_q       <= off_q + ursp.n;
			end else if (seg.ready) begin
				seg_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						lba_q       <= {1'b0, req.data.start_lba};
						left_q      <= req.data.sector_count;
						off_q       <= '0;
						idx_q       <= '0;
						nkeys_q     <= (key_count > MAX_K) ? MAX_K : key_count;
						crypt_act_q <= req.data.is_read ? lrcs_pkg::ACT_DECRYPT
							: lrcs_pkg::ACT_ENCRYPT;
						state_q     <= S_COPY;
					end
				end
				S_COPY: begin
					if (!walk_more) begin
						state_q <= S_TAIL;
					end else if (step) begin
						state_q <= S_CRYPT;
					end
				end
				S_CRYPT: begin
					if (step) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_COPY;
					end
				end
				S_TAIL: begin
					if (step) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			seg_data_q.action       <= (state_q == S_CRYPT) ? crypt_act_q : lrcs_pkg::ACT_COPY;
			seg_data_q.key_index    <= (state_q == S_CRYPT) ? idx_q : '0;
			seg_data_q.seg_lba      <= lba_q[lrcs_pkg::LBA_W-1:0];
			seg_data_q.seg_sectors  <= ursp.n;
			seg_data_q.seg_offset   <= off_q;
			seg_data_q.last_segment <= (left_nxt == '0);
		end
	end

endmodule

// ----- sv/lrcs_checker.sv -----
// lrcs_checker: port-level assertions for the segmenter, bound to the top level.
// Depends on lrcs_pkg and lba_range_crypt_segmenter.
module lrcs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                seg_valid,
	input logic                seg_ready,
	input lrcs_pkg::out_word_t seg_data
);

	a_seg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(seg_data))
		else $error("segment word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("access accepted while previous access in work");

	a_nonzero_seg: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> seg_data.seg_sectors != '0)
		else $error("empty segment");

	a_copy_key: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_data.action == lrcs_pkg::ACT_COPY |-> seg_data.key_index == '0)
		else $error("copy segment carries a key index");

endmodule

bind lba_range_crypt_segmenter lrcs_checker u_lrcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.seg_valid (seg.valid),
	.seg_ready (seg.ready),
	.seg_data  (seg.data)
);

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for lba_range_crypt_segmenter. Access words are split by a
// local segment predictor and compared with the segment stream under random stalls.
// Depends on lrcs_pkg, lrcs_if and the segmenter RTL.
module tb_top;
	import lrcs_pkg::*;

	typedef enum int {
		CFG_KEY_COUNT = 0,
		CFG_R0_LOW,
		CFG_R0_HIGH,
		CFG_R1_LOW,
		CFG_R1_HIGH,
		CFG_R2_LOW,
		CFG_R2_HIGH,
		CFG_SPARE
	} cfg_reg_t;

	localparam logic [LBA_W-1:0] LBA_TOP = '1;
	localparam logic [LBA_W-1:0] BASE_A  = 48'h0012_3456_7000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	lrcs_in_if  req_if();
	lrcs_out_if seg_if();

	lba_range_crypt_segmenter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.seg     (seg_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// register shadow
	logic [KEY_W-1:0] cfg_keys;
	range_t           cfg_rng[3];

	in_word_t    access_q[$];
	out_word_t   seg_due[$];
	int          err_cnt;
	bit          src_calm;
	bit          snk_calm;
	int unsigned src_hold;
	int unsigned snk_hold;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic logic [LBA_W-1:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic int unsigned idle_draw(bit calm);
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic void flag(string msg);
		if (err_cnt < 10) begin
			$display("%0t: %s", $time, msg);
		end
		err_cnt++;
	endfunction

	// expected segments for one accepted access, from the current register shadow
	function automatic void split_access(in_word_t acc);
		logic [RUN_W-1:0] cur;
		logic [RUN_W-1:0] span;
		logic [CNT_W-1:0] left;
		logic [CNT_W-1:0] take;
		act_t             crypt_act;
		out_word_t        segs[$];
		int               nk;
		cur = RUN_W'(acc.start_lba);
		left = acc.sector_count;
		crypt_act = acc.is_read ? ACT_DECRYPT : ACT_ENCRYPT;
		nk = (int'(cfg_keys) > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(cfg_keys);
		for (int i = 0; i < nk && left != 0; i++) begin
			if (RUN_W'(cfg_rng[i].low) > cur) begin
				span = RUN_W'(cfg_rng[i].low) - cur;
				take = (span > RUN_W'(SEG_CAP)) ? SEG_CAP : span[CNT_W-1:0];
				if (take > left) begin
					take = left;
				end
				segs.push_back('{ACT_COPY, '0, cur[LBA_W-1:0], take,
					acc.sector_count - left, 1'b0});
				left -= take;
				cur += RUN_W'(take);
			end
			if (left != 0 && RUN_W'(cfg_rng[i].high) >= cur) begin
				span = RUN_W'(cfg_rng[i].high) - cur;
				take = (span >= RUN_W'(SEG_CAP)) ? SEG_CAP : span[CNT_W-1:0] + 1'b1;
				if (take > left) begin
					take = left;
				end
				segs.push_back('{crypt_act, KEY_W'(i), cur[LBA_W-1:0], take,
					acc.sector_count - left, 1'b0});
				left -= take;
				cur += RUN_W'(take);
			end
		end
		// tail copy; past the top of the space the LBA wraps
		if (left != 0) begin
			segs.push_back('{ACT_COPY, '0, cur[LBA_W-1:0], left,
				acc.sector_count - left, 1'b0});
		end
		if (segs.size() != 0) begin
			segs[segs.size()-1].last_segment = 1'b1;
		end
		foreach (segs[j]) begin
			seg_due.push_back(segs[j]);
		end
	endfunction

	function automatic void check_segment(out_word_t got);
		out_word_t want;
		if (seg_due.size() == 0) begin
			flag($sformatf("segment word with nothing due: %p", got));
			return;
		end
		want = seg_due.pop_front();
		if (got.action !== want.action || got.key_index !== want.key_index ||
				got.seg_lba !== want.seg_lba || got.seg_sectors !== want.seg_sectors ||
				got.seg_offset !== want.seg_offset ||
				got.last_segment !== want.last_segment) begin
			flag($sformatf("segment mismatch: exp %p got %p", want, got));
		end
	endfunction

	// access driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			src_hold <= 0;
		end else if (req_if.valid && !req_if.ready) begin
			// word held
		end else begin
			if (req_if.valid) begin
				split_access(req_if.data);
			end
			if (src_hold != 0) begin
				src_hold <= src_hold - 1;
				req_if.valid <= 1'b0;
			end else if (access_q.size() != 0) begin
				req_if.data <= access_q.pop_front();
				req_if.valid <= 1'b1;
				src_hold <= idle_draw(src_calm);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// segment monitor
	always @(posedge clk) begin : seg_mon
		int unsigned hold;
		if (!arst_n) begin
			seg_if.ready <= 1'b0;
			snk_hold <= 0;
		end else if (seg_if.valid && seg_if.ready) begin
			check_segment(seg_if.data);
			hold = idle_draw(snk_calm);
			snk_hold <= hold;
			seg_if.ready <= (hold == 0);
		end else if (snk_hold != 0) begin
			snk_hold <= snk_hold - 1;
			seg_if.ready <= (snk_hold == 1);
		end else begin
			seg_if.ready <= 1'b1;
		end
	end

	task automatic cfg_write(cfg_reg_t idx, logic [APB_DW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(int'(idx) * 8);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			CFG_KEY_COUNT: cfg_keys = val[KEY_W-1:0];
			CFG_R0_LOW:    cfg_rng[0].low = val[LBA_W-1:0];
			CFG_R0_HIGH:   cfg_rng[0].high = val[LBA_W-1:0];
			CFG_R1_LOW:    cfg_rng[1].low = val[LBA_W-1:0];
			CFG_R1_HIGH:   cfg_rng[1].high = val[LBA_W-1:0];
			CFG_R2_LOW:    cfg_rng[2].low = val[LBA_W-1:0];
			CFG_R2_HIGH:   cfg_rng[2].high = val[LBA_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits are random; only the register width is kept
	task automatic load_config(logic [KEY_W-1:0] keys,
			logic [LBA_W-1:0] l0, logic [LBA_W-1:0] h0,
			logic [LBA_W-1:0] l1, logic [LBA_W-1:0] h1,
			logic [LBA_W-1:0] l2, logic [LBA_W-1:0] h2);
		cfg_write(CFG_KEY_COUNT, {$urandom, 30'($urandom), keys});
		cfg_write(CFG_R0_LOW, {16'($urandom), l0});
		cfg_write(CFG_R0_HIGH, {16'($urandom), h0});
		cfg_write(CFG_R1_LOW, {16'($urandom), l1});
		cfg_write(CFG_R1_HIGH, {16'($urandom), h1});
		cfg_write(CFG_R2_LOW, {16'($urandom), l2});
		cfg_write(CFG_R2_HIGH, {16'($urandom), h2});
	endtask

	task automatic shuffle_config();
		logic [LBA_W-1:0] base;
		logic [LBA_W-1:0] lo[3];
		logic [LBA_W-1:0] hi[3];
		int               nk;
		case ($urandom_range(0, 5))
			0: base = '0;
			1: base = LBA_TOP - $urandom_range(0, 600);
			default: base = rand48();
		endcase
		for (int k = 0; k < 3; k++) begin
			lo[k] = base + $urandom_range(0, 400);
			case ($urandom_range(0, 5))
				0: hi[k] = lo[k] - $urandom_range(1, 60);
				1: hi[k] = lo[k];
				2: hi[k] = lo[k] + $urandom_range(65000, 300000);
				3: begin
					lo[k] = base + $urandom_range(0, 120000);
					hi[k] = lo[k] + $urandom_range(0, 100000);
				end
				default: hi[k] = lo[k] + $urandom_range(0, 200);
			endcase
		end
		nk = $urandom_range(0, 5);
		load_config(KEY_W'(nk > 3 ? 3 : nk), lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
	endtask

	// most starts cluster around the range bounds; some are random or near the top of the space
	function automatic in_word_t make_access();
		in_word_t         acc;
		logic [LBA_W-1:0] anchor;
		int               r;
		r = $urandom_range(0, 2);
		anchor = $urandom_range(0, 1) ? cfg_rng[r].low : cfg_rng[r].high;
		case ($urandom_range(0, 9))
			0: acc.start_lba = rand48();
			1: acc.start_lba = LBA_TOP - $urandom_range(0, 40);
			2: acc.start_lba = anchor - $urandom_range(0, 150000);
			default: acc.start_lba = anchor - $urandom_range(0, 64) + $urandom_range(0, 64);
		endcase
		case ($urandom_range(0, 11))
			0: acc.sector_count = '0;
			1: acc.sector_count = SEG_CAP;
			2: acc.sector_count = CNT_W'($urandom);
			3: acc.sector_count = CNT_W'($urandom_range(40000, 65535));
			default: acc.sector_count = CNT_W'($urandom_range(1, 160));
		endcase
		acc.is_read = 1'($urandom_range(0, 1));
		return acc;
	endfunction

	function automatic void queue_access(logic [LBA_W-1:0] lba, logic [CNT_W-1:0] cnt,
			logic rd);
		access_q.push_back('{lba, cnt, rd});
	endfunction

	task automatic settle();
		do begin
			@(negedge clk);
		end while (access_q.size() != 0 || req_if.valid || seg_due.size() != 0);
		repeat (16) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		seg_if.ready = 1'b0;
		err_cnt = 0;
		src_calm = 1'b0;
		snk_calm = 1'b0;
		cfg_keys = '0;
		foreach (cfg_rng[k]) begin
			cfg_rng[k] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: no ranges in use
		queue_access('0, '0, 1'b1);
		queue_access('0, 16'd1, 1'b1);
		queue_access(LBA_TOP, 16'd1, 1'b0);
		queue_access(LBA_TOP, SEG_CAP, 1'b1);
		queue_access(rand48(), SEG_CAP, 1'b0);
		settle();

		// three ordered ranges with gaps
		load_config(2'd3, BASE_A + 16, BASE_A + 31, BASE_A + 48, BASE_A + 63,
			BASE_A + 80, BASE_A + 95);
		cfg_write(CFG_SPARE, '1);
		@(negedge clk);
		queue_access(BASE_A, 16'd200, 1'b1);
		queue_access(BASE_A + 20, 16'd5, 1'b0);
		queue_access(BASE_A + 40, 16'd30, 1'b1);
		queue_access(BASE_A + 100, 16'd10, 1'b0);
		queue_access(BASE_A, '0, 1'b1);
		queue_access(BASE_A + 16, 16'd1, 1'b0);
		settle();

		// full-space range, inverted range, range at the top
		load_config(2'd3, '0, LBA_TOP, LBA_TOP, '0, LBA_TOP, LBA_TOP);
		@(negedge clk);
		queue_access(LBA_TOP - 2, 16'd10, 1'b0);
		queue_access('0, SEG_CAP, 1'b1);
		queue_access(LBA_TOP, SEG_CAP, 1'b1);
		queue_access(LBA_TOP, 16'd1, 1'b0);
		settle();

		// unsorted ranges
		load_config(2'd2, BASE_A + 100, BASE_A + 120, BASE_A + 10, BASE_A + 20,
			BASE_A + 5, BASE_A + 6);
		@(negedge clk);
		queue_access(BASE_A, 16'd150, 1'b1);
		queue_access(BASE_A + 5, 16'd10, 1'b0);
		queue_access(BASE_A + 12, 16'd100, 1'b0);
		settle();

		// one wide range, segments at the cap
		load_config(2'd1, BASE_A + 100000, BASE_A + 400000, '0, '0, '0, '0);
		@(negedge clk);
		queue_access(BASE_A, SEG_CAP, 1'b1);
		queue_access(BASE_A + 50000, SEG_CAP, 1'b0);
		queue_access(BASE_A + 200000, SEG_CAP, 1'b1);
		settle();

		for (int ph = 0; ph < 10; ph++) begin
			src_calm = ($urandom_range(0, 3) == 0);
			snk_calm = ($urandom_range(0, 3) == 0);
			shuffle_config();
			@(negedge clk);
			repeat (42) access_q.push_back(make_access());
			settle();
		end

		if (err_cnt == 0 && seg_due.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end
endmodule

// ----- files.f -----
sv/lrcs_pkg.sv
sv/lrcs_if.sv
sv/lrcs_cfg.sv
sv/lrcs_seg_unit.sv
sv/lba_range_crypt_segmenter.sv
sv/lrcs_checker.sv
test/tb_top.sv
